### rtl/core/rsa_pkg.sv
// Shared types, constants and codes of the region sector allocator.
package rsa_pkg;

    localparam int MAX_SECTORS  = 4096;
    localparam int SECT_W       = $clog2(MAX_SECTORS);
    localparam int END_W        = SECT_W + 1;
    localparam int SLOT_COUNT   = 1024;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int HDR_BYTES    = 5;
    localparam int ROW_BITS     = 256;
    localparam int ROW_CNT      = MAX_SECTORS / ROW_BITS;
    localparam int ROW_W        = $clog2(ROW_CNT);
    localparam int COL_W        = $clog2(ROW_BITS);
    localparam int CHUNK        = 8;
    localparam int CHUNK_W      = $clog2(ROW_BITS / CHUNK);
    localparam int LEN_W        = 20;
    localparam int NEED_W       = 8;
    localparam int LF_W         = 24;

    // Function codes
    localparam logic [1:0] FN_LOAD   = 2'd0;
    localparam logic [1:0] FN_LOOKUP = 2'd1;
    localparam logic [1:0] FN_WRITE  = 2'd2;

    // Status codes
    localparam logic [3:0] ST_LOADED    = 4'd0;
    localparam logic [3:0] ST_REJECTED  = 4'd1;
    localparam logic [3:0] ST_ABSENT    = 4'd2;
    localparam logic [3:0] ST_PRESENT   = 4'd3;
    localparam logic [3:0] ST_IN_PLACE  = 4'd4;
    localparam logic [3:0] ST_REUSED    = 4'd5;
    localparam logic [3:0] ST_APPENDED  = 4'd6;
    localparam logic [3:0] ST_FULL      = 4'd7;
    localparam logic [3:0] ST_TOO_LARGE = 4'd8;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot;
        logic [NEED_W-1:0] need;
        logic              too_large;
        logic [LF_W-1:0]   lf;
        logic [7:0]        lc;
    } rsa_item_t;

    typedef struct packed {
        logic [3:0]        status;
        logic [SECT_W-1:0] run_start;
        logic [7:0]        run_length;
    } rsa_res_t;

endpackage

### rtl/core/rsa_front.sv
// Front end: accepts words, sizes the write run and queues decoded items.
module rsa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          func,
    input  logic [4:0]          slot_x,
    input  logic [4:0]          slot_z,
    input  logic [19:0]         payload_length,
    input  logic [23:0]         load_first_sector,
    input  logic [7:0]          load_sector_count,
    input  logic                clearing,
    output logic                q_valid,
    output rsa_pkg::rsa_item_t  q_item,
    input  logic                q_pop
);

    rsa_pkg::rsa_item_t ent_reg [2];
    logic               wp_reg, wp_next;
    logic               rp_reg, rp_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [20:0]        len_sum;
    logic [8:0]         need9;
    rsa_pkg::rsa_item_t item_in;
    logic               do_push, do_pop;

    // Size the run: ceil((len + header) / sector)
    assign len_sum = {1'b0, payload_length}
                   + 21'(rsa_pkg::HDR_BYTES + rsa_pkg::SECTOR_BYTES - 1);
    assign need9   = len_sum[20:rsa_pkg::SECTOR_SHIFT];

    always_comb
    begin
        item_in.func      = func;
        item_in.slot      = {slot_z, slot_x};
        item_in.need      = need9[7:0];
        item_in.too_large = need9[8];
        item_in.lf        = load_first_sector;
        item_in.lc        = load_sector_count;
    end

    assign full    = (cnt_reg == 2'd2) || clearing;
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign do_pop  = q_pop && q_valid;
    assign q_item  = ent_reg[rp_reg];

    // Advance queue pointers
    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg] <= item_in;
        end
    end

endmodule

### rtl/core/rsa_result_q.sv
// Two-entry result queue toward the consumer.
module rsa_result_q (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  rsa_pkg::rsa_res_t res_in,
    output logic              res_full,
    output logic              empty,
    input  logic              pop,
    output rsa_pkg::rsa_res_t res_out
);

    rsa_pkg::rsa_res_t ent_reg [2];
    logic              wp_reg, wp_next;
    logic              rp_reg, rp_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign res_out  = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg] <= res_in;
        end
    end

endmodule

### rtl/core/rsa_back.sv
// Back end: slot table, free sector bitmap, first-fit scan and updates.
module rsa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        cfg_data,
    output logic               clearing,
    input  logic               q_valid,
    input  rsa_pkg::rsa_item_t q_item,
    output logic               q_pop,
    output logic               res_push,
    output rsa_pkg::rsa_res_t  res_out,
    input  logic               res_full
);

    localparam int SW = rsa_pkg::SECT_W;
    localparam int EW = rsa_pkg::END_W;
    localparam int RB = rsa_pkg::ROW_BITS;
    localparam int RW = rsa_pkg::ROW_W;
    localparam int CW = rsa_pkg::CHUNK_W;
    localparam int TW = SW + 8;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_TRD    = 9'b000000100,
        S_SRD    = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_RSTART = 9'b000100000,
        S_RRD    = 9'b001000000,
        S_RWR    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    // Memories
    logic [TW-1:0] tbl [rsa_pkg::SLOT_COUNT];
    logic [RB-1:0] fmap [rsa_pkg::ROW_CNT];
    logic [TW-1:0] tbl_rd_reg;
    logic [RB-1:0] fm_rd_reg;

    logic                      tbl_we, tbl_re;
    logic [rsa_pkg::SLOT_W-1:0] tbl_wa, tbl_ra;
    logic [TW-1:0]             tbl_wd;
    logic                      fm_we, fm_re;
    logic [RW-1:0]             fm_wa, fm_ra;
    logic [RB-1:0]             fm_wd;

    state_t                     state_reg, state_next;
    logic [rsa_pkg::SLOT_W-1:0] clr_reg, clr_next;
    rsa_pkg::rsa_item_t         item_reg, item_next;
    logic [EW-1:0]              end_reg, end_next;
    logic [SW-1:0]              olds_reg, olds_next;
    logic [EW-1:0]              olde_reg, olde_next;
    logic [RW-1:0]              rr_reg, rr_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [7:0]                 run_reg, run_next;
    logic [SW-1:0]              start_reg, start_next;
    logic [EW-1:0]              lo_reg, lo_next;
    logic [EW-1:0]              hi_reg, hi_next;
    logic                       val_reg, val_next;
    logic                       pend_reg, pend_next;
    rsa_pkg::rsa_res_t          res_reg, res_next;

    // Scan and helper signals
    logic [SW-1:0]  old_s;
    logic [7:0]     old_l;
    logic [EW-1:0]  old_sum;
    logic [24:0]    load_end;
    logic           load_rej;
    logic [12:0]    cfg_clamp;
    logic [7:0]     chunk_bits;
    logic [EW-1:0]  idx;
    logic [7:0]     run_v;
    logic           found_v, stop_v, avail;
    logic [SW-1:0]  start_v;
    logic [EW+1:0]  app_end;
    logic [SW-1:0]  start_c;
    logic           commit;
    logic [EW-1:0]  sec;
    logic [EW-1:0]  hi_last;
    logic [RB-1:0]  row_init;

    assign cfg_ready = 1'b1;
    assign clearing  = (state_reg == S_CLEAR);
    assign res_out   = res_reg;
    assign res_push  = (state_reg == S_OUT);

    assign old_s    = tbl_rd_reg[TW-1:8];
    assign old_l    = tbl_rd_reg[7:0];
    assign old_sum  = {1'b0, old_s} + EW'(old_l);
    assign load_end = {1'b0, item_reg.lf} + 25'(item_reg.lc);
    assign load_rej = (load_end > 25'(end_reg)) || (item_reg.lf[23:SW] != '0);
    assign hi_last  = hi_reg - EW'(1);
    assign app_end  = (EW+2)'(end_reg) + (EW+2)'(item_reg.need);

    // Clamp the opening size
    always_comb
    begin
        cfg_clamp = cfg_data;
        if (cfg_data < 13'd2)
        begin
            cfg_clamp = 13'd2;
        end
        else if (cfg_data > 13'(rsa_pkg::MAX_SECTORS))
        begin
            cfg_clamp = 13'(rsa_pkg::MAX_SECTORS);
        end
    end

    // Initial bitmap row: all free but the two header sectors
    always_comb
    begin
        row_init = '1;
        if (clr_reg == '0)
        begin
            row_init[1:0] = 2'b00;
        end
    end

    // Walk one chunk of the bitmap, old run counted free
    always_comb
    begin
        chunk_bits = fm_rd_reg[{k_reg, 3'b000} +: rsa_pkg::CHUNK];
        run_v      = run_reg;
        found_v    = 1'b0;
        stop_v     = 1'b0;
        start_v    = '0;
        idx        = '0;
        avail      = 1'b0;
        for (int j = 0; j < rsa_pkg::CHUNK; j++)
        begin
            idx = EW'({rr_reg, k_reg, 3'b000}) + EW'(j);
            if (!found_v && !stop_v)
            begin
                if (idx >= end_reg)
                begin
                    stop_v = 1'b1;
                end
                else
                begin
                    avail = chunk_bits[j] || (idx >= EW'(2) && idx >= {1'b0, olds_reg}
                                              && idx < olde_reg);
                    run_v = avail ? run_v + 8'd1 : 8'd0;
                    if (run_v == item_reg.need)
                    begin
                        found_v = 1'b1;
                        start_v = SW'(idx + EW'(1) - EW'(item_reg.need));
                    end
                end
            end
        end
    end

    // Sequence the back end
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        end_next   = end_reg;
        olds_next  = olds_reg;
        olde_next  = olde_reg;
        rr_next    = rr_reg;
        k_next     = k_reg;
        run_next   = run_reg;
        start_next = start_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        val_next   = val_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        tbl_we     = 1'b0;
        tbl_wa     = item_reg.slot;
        tbl_wd     = '0;
        tbl_re     = 1'b0;
        tbl_ra     = q_item.slot;
        fm_we      = 1'b0;
        fm_wa      = rr_reg;
        fm_wd      = '0;
        fm_re      = 1'b0;
        fm_ra      = rr_reg;
        commit     = 1'b0;
        start_c    = '0;
        sec        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                tbl_we = 1'b1;
                tbl_wa = clr_reg;
                tbl_wd = '0;
                if (clr_reg < rsa_pkg::SLOT_W'(rsa_pkg::ROW_CNT))
                begin
                    fm_we = 1'b1;
                    fm_wa = RW'(clr_reg);
                    fm_wd = row_init;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    tbl_re     = 1'b1;
                    item_next  = q_item;
                    state_next = S_TRD;
                end
            end
            S_TRD:
            begin
                res_next.run_start  = old_s;
                res_next.run_length = old_l;
                olds_next           = old_s;
                olde_next           = (old_sum > end_reg) ? end_reg : old_sum;
                case (item_reg.func)
                    rsa_pkg::FN_LOAD:
                    begin
                        tbl_we = 1'b1;
                        if (load_rej)
                        begin
                            tbl_wd              = '0;
                            res_next.status     = rsa_pkg::ST_REJECTED;
                            res_next.run_start  = '0;
                            res_next.run_length = '0;
                            state_next          = S_OUT;
                        end
                        else
                        begin
                            tbl_wd              = {item_reg.lf[SW-1:0], item_reg.lc};
                            res_next.status     = rsa_pkg::ST_LOADED;
                            res_next.run_start  = item_reg.lf[SW-1:0];
                            res_next.run_length = item_reg.lc;
                            lo_next             = {1'b0, item_reg.lf[SW-1:0]};
                            hi_next             = EW'(load_end);
                            val_next            = 1'b0;
                            pend_next           = 1'b0;
                            state_next          = S_RSTART;
                        end
                    end
                    rsa_pkg::FN_WRITE:
                    begin
                        if (item_reg.too_large)
                        begin
                            res_next.status = rsa_pkg::ST_TOO_LARGE;
                            state_next      = S_OUT;
                        end
                        else if (item_reg.need == old_l)
                        begin
                            res_next.status = rsa_pkg::ST_IN_PLACE;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            rr_next    = '0;
                            k_next     = '0;
                            run_next   = '0;
                            state_next = S_SRD;
                        end
                    end
                    default:
                    begin
                        res_next.status = (old_s == '0) ? rsa_pkg::ST_ABSENT
                                                        : rsa_pkg::ST_PRESENT;
                        state_next      = S_OUT;
                    end
                endcase
            end
            S_SRD:
            begin
                fm_re      = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                run_next = run_v;
                if (found_v)
                begin
                    commit          = 1'b1;
                    start_c         = start_v;
                    res_next.status = rsa_pkg::ST_REUSED;
                end
                else if (stop_v || ({rr_reg, k_reg} == '1))
                begin
                    if (app_end <= (EW+2)'(rsa_pkg::MAX_SECTORS))
                    begin
                        commit          = 1'b1;
                        start_c         = SW'(end_reg);
                        end_next        = EW'(app_end);
                        res_next.status = rsa_pkg::ST_APPENDED;
                    end
                    else
                    begin
                        res_next.status = rsa_pkg::ST_FULL;
                        state_next      = S_OUT;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg == '1)
                    begin
                        rr_next    = rr_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
                // Record the new run, free the old one, then claim the new one
                if (commit)
                begin
                    tbl_we              = 1'b1;
                    tbl_wd              = {start_c, item_reg.need};
                    res_next.run_start  = start_c;
                    res_next.run_length = item_reg.need;
                    start_next          = start_c;
                    lo_next             = (olds_reg < SW'(2)) ? EW'(2) : {1'b0, olds_reg};
                    hi_next             = olde_reg;
                    val_next            = 1'b1;
                    pend_next           = 1'b1;
                    state_next          = S_RSTART;
                end
            end
            S_RSTART:
            begin
                if (lo_reg < hi_reg)
                begin
                    rr_next    = lo_reg[SW-1:rsa_pkg::COL_W];
                    state_next = S_RRD;
                end
                else if (pend_reg)
                begin
                    lo_next   = {1'b0, start_reg};
                    hi_next   = {1'b0, start_reg} + EW'(item_reg.need);
                    val_next  = 1'b0;
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RRD:
            begin
                fm_re      = 1'b1;
                state_next = S_RWR;
            end
            S_RWR:
            begin
                fm_we = 1'b1;
                for (int b = 0; b < RB; b++)
                begin
                    sec      = {1'b0, rr_reg, b[rsa_pkg::COL_W-1:0]};
                    fm_wd[b] = (sec >= lo_reg && sec < hi_reg) ? val_reg : fm_rd_reg[b];
                end
                if (rr_reg == hi_last[SW-1:rsa_pkg::COL_W])
                begin
                    lo_next    = hi_reg;
                    state_next = S_RSTART;
                end
                else
                begin
                    rr_next    = rr_reg + 1'b1;
                    state_next = S_RRD;
                end
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Re-open the store on a configuration write
        if (cfg_valid)
        begin
            end_next   = cfg_clamp;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            end_reg   <= EW'(2);
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            end_reg   <= end_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        olds_reg  <= olds_next;
        olde_reg  <= olde_next;
        rr_reg    <= rr_next;
        k_reg     <= k_next;
        run_reg   <= run_next;
        start_reg <= start_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        val_reg   <= val_next;
        res_reg   <= res_next;
    end

    // Slot table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl[tbl_wa] <= tbl_wd;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= tbl[tbl_ra];
        end
    end

    // Free bitmap memory, one row of sectors per word
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fmap[fm_wa] <= fm_wd;
        end
        if (fm_re)
        begin
            fm_rd_reg <= fmap[fm_ra];
        end
    end

endmodule

### rtl/core/region_sector_allocator.sv
// Top level of the region sector allocator.
//
//  channel   handshake              word
//  input     push / full            func, slot_x, slot_z, payload_length,
//                                   load_first_sector, load_sector_count
//  result    empty / pop            status, run_start, run_length
//  config    cfg_valid / cfg_ready  cfg_data (sectors present at open)
//
// A lookup, a rejected load or a write that needs no search reads the slot table
// and returns its result word; an accepted load also starts its range and marks
// each bitmap row it covers (read-modify-write of a row).
// A write that must search scans 8 sectors per cycle plus one row read per
// 256 sectors until it finds a fit or reaches the end of the open sectors.
// After reset and after each config write a clearing pass over all 1024 slots
// runs while full stays high. Input and result queues are two words deep.
module region_sector_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [4:0]  slot_x,
    input  logic [4:0]  slot_z,
    input  logic [19:0] payload_length,
    input  logic [23:0] load_first_sector,
    input  logic [7:0]  load_sector_count,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  status,
    output logic [11:0] run_start,
    output logic [7:0]  run_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);

    logic               clearing;
    logic               q_valid, q_pop;
    rsa_pkg::rsa_item_t q_item;
    logic               res_push, res_full;
    rsa_pkg::rsa_res_t  res_in, res_out;

    rsa_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .func              (func),
        .slot_x            (slot_x),
        .slot_z            (slot_z),
        .payload_length    (payload_length),
        .load_first_sector (load_first_sector),
        .load_sector_count (load_sector_count),
        .clearing          (clearing),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop)
    );

    rsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_push  (res_push),
        .res_out   (res_in),
        .res_full  (res_full)
    );

    rsa_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign status     = res_out.status;
    assign run_start  = res_out.run_start;
    assign run_length = res_out.run_length;

endmodule

### rtl/core/rsa_checker.sv
// Port-level checks of the region sector allocator, bound to the top level.
module rsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  status,
    input logic [11:0] run_start,
    input logic [7:0]  run_length
);

    // Hold the status and start of a waiting result word until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status) && $stable(run_start))
        else $error("result word changed while waiting");

    // Report only defined status codes
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> status <= rsa_pkg::ST_TOO_LARGE)
        else $error("undefined status code");

    // Absent slot has a zero start
    a_absent: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == rsa_pkg::ST_ABSENT |-> run_start == 12'd0)
        else $error("absent slot with nonzero start");

    // Rejected load clears the entry
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == rsa_pkg::ST_REJECTED |-> run_start == 12'd0
            && run_length == 8'd0)
        else $error("rejected load left an entry");

endmodule

bind region_sector_allocator rsa_checker u_rsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .run_start  (run_start),
    .run_length (run_length)
);
